[rtl/imd_pkg.sv]
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types and constants for the IPP message deframer: parse phases,
// byte kinds and the per-byte result word.
// ----------------------------------------------------------------------------
package imd_pkg;

  // parse phase of the current message
  typedef enum logic [3:0] {
    PH_HEADER       = 4'd0,
    PH_FIRST_GROUP  = 4'd1,
    PH_VALUE_TAG    = 4'd2,
    PH_NAME_LEN_HI  = 4'd3,
    PH_NAME_LEN_LO  = 4'd4,
    PH_NAME         = 4'd5,
    PH_VALUE_LEN_HI = 4'd6,
    PH_VALUE_LEN_LO = 4'd7,
    PH_VALUE        = 4'd8,
    PH_DELIM        = 4'd9,
    PH_DATA         = 4'd10
  } phase_t;

  // classification of one message byte
  typedef enum logic [3:0] {
    KIND_HEADER     = 4'd0,
    KIND_GROUP_TAG  = 4'd1,
    KIND_VALUE_TAG  = 4'd2,
    KIND_NAME_LEN   = 4'd3,
    KIND_NAME       = 4'd4,
    KIND_VALUE_LEN  = 4'd5,
    KIND_VALUE      = 4'd6,
    KIND_END_TAG    = 4'd7,
    KIND_DATA       = 4'd8,
    KIND_MALFORMED  = 4'd9,
    KIND_DISCARDED  = 4'd10
  } kind_t;

  // delimiter codes
  localparam logic [7:0] END_TAG       = 8'h03;
  localparam logic [7:0] GROUP_TAG_MIN = 8'h01;
  localparam logic [7:0] GROUP_TAG_MAX = 8'h09;

  // header is bytes 0 through 7
  localparam logic [2:0] HDR_LAST_POS  = 3'd7;

  // reset value of the minimum message length
  localparam logic [7:0] MIN_BYTES_RST = 8'd9;

  // result word for one byte
  typedef struct packed {
    kind_t        byte_kind;
    logic [7:0]   byte_echo;
    logic [7:0]   current_group;
    logic         starts_attribute;
    logic [15:0]  field_offset;
    logic [7:0]   version_major;
    logic [7:0]   version_minor;
    logic [15:0]  op_or_status;
    logic [31:0]  request_ident;
    logic         message_done;
  } result_t;

endpackage

[rtl/ipp_message_deframer.sv]
// ----------------------------------------------------------------------------
// ipp_message_deframer
// Streaming IPP message parser: classifies each byte as header, group tag,
// value tag, length, name, value, end tag or data, decodes the header and
// flags messages that end early or fall short of the minimum length.
//
//   channel  | signals                           | dir | contents
//   ---------+-----------------------------------+-----+----------------------
//   in       | in_valid, in_ready                | in  | message_byte, last_byte
//   out      | out_valid, out_ready              | out | byte_kind .. message_done
//   cfg      | cfg_valid, cfg_ready, cfg_data    | in  | min_message_bytes
//
// One word per cycle while out_ready is high; a result appears in the cycle
// after its byte is taken; the single result register follows the classifier.
// A stalled output holds its word; the input is taken whenever the result
// register is empty or being emptied in the same cycle.
// Synchronous active-high reset clears the parse state, the output valid and
// sets min_message_bytes to 9; the cfg port is always ready.
// ----------------------------------------------------------------------------
module ipp_message_deframer
  import imd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // byte input
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   message_byte,
  input  logic         last_byte,
  // result output
  output logic         out_valid,
  input  logic         out_ready,
  output logic [3:0]   byte_kind,
  output logic [7:0]   byte_echo,
  output logic [7:0]   current_group,
  output logic         starts_attribute,
  output logic [15:0]  field_offset,
  output logic [7:0]   version_major,
  output logic [7:0]   version_minor,
  output logic [15:0]  op_or_status,
  output logic [31:0]  request_ident,
  output logic         message_done,
  // configuration write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);

  logic        accept;
  logic [7:0]  min_message_bytes;
  result_t     parse_res;
  result_t     out_res;

  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // minimum message length register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_message_bytes <= MIN_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_message_bytes <= cfg_data;
    end
  end

  // byte classifier and parse state
  imd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .message_byte (message_byte),
    .last_byte    (last_byte),
    .min_bytes    (min_message_bytes),
    .res          (parse_res)
  );

  // result register
  imd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .load_ready (in_ready),
    .load_res   (parse_res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  // result fields out to ports
  assign byte_kind        = out_res.byte_kind;
  assign byte_echo        = out_res.byte_echo;
  assign current_group    = out_res.current_group;
  assign starts_attribute = out_res.starts_attribute;
  assign field_offset     = out_res.field_offset;
  assign version_major    = out_res.version_major;
  assign version_minor    = out_res.version_minor;
  assign op_or_status     = out_res.op_or_status;
  assign request_ident    = out_res.request_ident;
  assign message_done     = out_res.message_done;

endmodule

[rtl/imd_parser.sv]
// ----------------------------------------------------------------------------
// imd_parser
// Parse state registers and the single-pass next-state logic that classifies
// one message byte and builds its result word.
// ----------------------------------------------------------------------------
module imd_parser
  import imd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  message_byte,
  input  logic        last_byte,
  input  logic [7:0]  min_bytes,
  output result_t     res
);

  phase_t       phase, phase_next;
  logic [15:0]  byte_count, byte_count_next;
  logic [15:0]  remaining_length, remaining_length_next;
  logic [7:0]   length_high, length_high_next;
  logic [15:0]  offset_count, offset_count_next;
  logic [7:0]   group_reg, group_reg_next;
  logic [7:0]   version_major, version_major_next;
  logic [7:0]   version_minor, version_minor_next;
  logic [15:0]  op_status_reg, op_status_reg_next;
  logic [31:0]  request_reg, request_reg_next;

  kind_t        kind;
  logic         starts;
  logic [15:0]  offset;
  logic [15:0]  len;
  logic [15:0]  remaining_dec;
  logic         is_group_tag;
  logic         ok_phase;
  logic         too_short;
  logic         malformed;

  assign len           = {length_high, message_byte};
  assign remaining_dec = remaining_length - 16'd1;
  assign is_group_tag  = (message_byte >= GROUP_TAG_MIN) &&
                         (message_byte <= GROUP_TAG_MAX) &&
                         (message_byte != END_TAG);

  // classify the byte and work out the next parse state
  always_comb begin
    phase_next            = phase;
    remaining_length_next = remaining_length;
    length_high_next      = length_high;
    offset_count_next     = offset_count;
    group_reg_next        = group_reg;
    version_major_next    = version_major;
    version_minor_next    = version_minor;
    op_status_reg_next    = op_status_reg;
    request_reg_next      = request_reg;
    kind                  = KIND_HEADER;
    starts                = 1'b0;
    offset                = 16'd0;

    unique case (phase)
      PH_HEADER: begin
        kind = KIND_HEADER;
        case (byte_count[2:0])
          3'd0:         version_major_next = message_byte;
          3'd1:         version_minor_next = message_byte;
          3'd2, 3'd3:   op_status_reg_next = {op_status_reg[7:0], message_byte};
          default:      request_reg_next   = {request_reg[23:0], message_byte};
        endcase
        if (byte_count[2:0] == HDR_LAST_POS) begin
          phase_next = PH_FIRST_GROUP;
        end
      end
      PH_FIRST_GROUP: begin
        if (message_byte == END_TAG) begin
          kind       = KIND_END_TAG;
          phase_next = PH_DATA;
        end else begin
          kind           = KIND_GROUP_TAG;
          group_reg_next = message_byte;
          phase_next     = PH_VALUE_TAG;
        end
      end
      PH_VALUE_TAG: begin
        kind       = KIND_VALUE_TAG;
        phase_next = PH_NAME_LEN_HI;
      end
      PH_NAME_LEN_HI: begin
        kind             = KIND_NAME_LEN;
        length_high_next = message_byte;
        phase_next       = PH_NAME_LEN_LO;
      end
      PH_NAME_LEN_LO: begin
        kind                  = KIND_NAME_LEN;
        remaining_length_next = len;
        offset_count_next     = 16'd0;
        if (len != 16'd0) begin
          starts     = 1'b1;
          phase_next = PH_NAME;
        end else begin
          phase_next = PH_VALUE_LEN_HI;
        end
      end
      PH_NAME: begin
        kind                  = KIND_NAME;
        offset                = offset_count;
        offset_count_next     = offset_count + 16'd1;
        remaining_length_next = remaining_dec;
        if (remaining_dec == 16'd0) begin
          phase_next = PH_VALUE_LEN_HI;
        end
      end
      PH_VALUE_LEN_HI: begin
        kind             = KIND_VALUE_LEN;
        length_high_next = message_byte;
        phase_next       = PH_VALUE_LEN_LO;
      end
      PH_VALUE_LEN_LO: begin
        kind                  = KIND_VALUE_LEN;
        remaining_length_next = len;
        offset_count_next     = 16'd0;
        phase_next            = (len != 16'd0) ? PH_VALUE : PH_DELIM;
      end
      PH_VALUE: begin
        kind                  = KIND_VALUE;
        offset                = offset_count;
        offset_count_next     = offset_count + 16'd1;
        remaining_length_next = remaining_dec;
        if (remaining_dec == 16'd0) begin
          phase_next = PH_DELIM;
        end
      end
      PH_DELIM: begin
        if (message_byte == END_TAG) begin
          kind       = KIND_END_TAG;
          phase_next = PH_DATA;
        end else if (is_group_tag) begin
          kind           = KIND_GROUP_TAG;
          group_reg_next = message_byte;
          phase_next     = PH_VALUE_TAG;
        end else begin
          kind       = KIND_VALUE_TAG;
          phase_next = PH_NAME_LEN_HI;
        end
      end
      default: begin
        kind       = KIND_DATA;
        phase_next = PH_DATA;
      end
    endcase

    // saturating byte count
    byte_count_next = (byte_count != 16'hffff) ? byte_count + 16'd1 : byte_count;

    // message end check
    ok_phase  = (phase_next == PH_DELIM) || (phase_next == PH_DATA);
    too_short = byte_count_next < {8'd0, min_bytes};
    malformed = last_byte && (!ok_phase || too_short);

    res.byte_kind        = malformed ? KIND_MALFORMED : kind;
    res.byte_echo        = message_byte;
    res.current_group    = group_reg_next;
    res.starts_attribute = malformed ? 1'b0 : starts;
    res.field_offset     = malformed ? 16'd0 : offset;
    res.version_major    = version_major_next;
    res.version_minor    = version_minor_next;
    res.op_or_status     = op_status_reg_next;
    res.request_ident    = request_reg_next;
    res.message_done     = last_byte;
  end

  // parse state, cleared at reset and after the last byte of a message
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase            <= PH_HEADER;
      byte_count       <= 16'd0;
      remaining_length <= 16'd0;
      length_high      <= 8'd0;
      offset_count     <= 16'd0;
      group_reg        <= 8'd0;
      version_major    <= 8'd0;
      version_minor    <= 8'd0;
      op_status_reg    <= 16'd0;
      request_reg      <= 32'd0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      remaining_length <= remaining_length_next;
      length_high      <= length_high_next;
      offset_count     <= offset_count_next;
      group_reg        <= group_reg_next;
      version_major    <= version_major_next;
      version_minor    <= version_minor_next;
      op_status_reg    <= op_status_reg_next;
      request_reg      <= request_reg_next;
    end
  end

`ifndef SYNTHESIS
  // a message end always leaves a fresh parser behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> (phase == PH_HEADER) && (byte_count == 16'd0))
    else $error("parser not cleared after last byte");

  // byte count steps by one per word until it saturates
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !last_byte && (byte_count != 16'hffff)
    |=> byte_count == $past(byte_count) + 16'd1)
    else $error("byte count did not advance");

  // inside a name or value there is always at least one byte left
  a_remaining_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAME) || (phase == PH_VALUE) |-> remaining_length != 16'd0)
    else $error("name or value phase with zero remaining length");

  // header phase only covers the first eight bytes
  a_header_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> byte_count < 16'd8)
    else $error("header phase past byte seven");
`endif

endmodule

[rtl/imd_out_reg.sv]
// ----------------------------------------------------------------------------
// imd_out_reg
// Result register with valid/ready handshake; takes a new word in the same
// cycle the held one is taken: one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module imd_out_reg
  import imd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load_valid,
  output logic     load_ready,
  input  result_t  load_res,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  logic load;

  assign load_ready = !out_valid || out_ready;
  assign load       = load_valid && load_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

`ifndef SYNTHESIS
  // a loaded word shows up as valid in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded word not presented");

  // a word nobody took and nothing replaced stays put
  a_hold_unloaded: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("stalled result changed");

  // the register empties only through a take with no new load
  a_empty_on_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !load_valid |=> !out_valid)
    else $error("result valid after take with nothing loaded");
`endif

endmodule
